// ----- sv/nnpo_pkg.sv -----
package nnpo_pkg;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_LEFT  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_GRAB  = 5'b01000,
    ST_SCAN  = 5'b10000
  } state_e;

  // coordinate axis handled by the shared distance unit
  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  // tag that travels with each axis through the distance pipeline
  typedef struct packed {
    logic  valid;
    axis_e axis;
  } tag_t;

  // output point index width
  localparam int unsigned INDEX_W = 6;

  // config port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index, taken from paddr bit 2
  localparam logic REG_START_LEFTMOST = 1'b0;

endpackage

// ----- sv/nearest_neighbor_point_order_top.sv -----
// Greedy nearest-neighbor point ordering.
// Input stream (s_axis): one 3D point per request, tlast marks the final
// point of a set. Up to MAX_POINTS points are stored; further points are
// dropped, but their tlast still closes the set.
// Output stream (m_axis): once the set is closed, every stored point is
// sent in greedy nearest-neighbor order, tlast on the final one.
// Config (APB): register 0 at address 0, start_leftmost in bit 0.
// Ordering: s_axis_tready is high while a set is loading. For each emitted
// point, the scan reads every unvisited point one coordinate axis at a
// time and skips visited points. Speed is limited by the single
// subtract/multiply/accumulate unit, which takes one coordinate axis per cycle,
// and the one memory read port. The leftmost start adds a pass over the
// x coordinates of all points. s_axis_tready is low while a set
// is being ordered.
// Reset: the set is empty, start_leftmost is 0, no result is pending.
// Stall: a result waits in the output register while the scan for the
// next point goes on; the next point is loaded once the register frees.
module nearest_neighbor_point_order_top
  import nnpo_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 64,
  parameter int unsigned COORD_WIDTH = 24,
  localparam int unsigned IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((INDEX_W + 3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pos_x, pos_y, pos_z
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,
  input  logic                  s_axis_tlast,
  // point_index, out_x, out_y, out_z
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned ROW_W = 3 * COORD_WIDTH;
  localparam int unsigned DW    = 2 * COORD_WIDTH + 2;
  localparam int unsigned SAT_W = 64;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    emit_q, emit_d;
  logic [CNT_W-1:0]    ic_q, ic_d;
  axis_e               ax_q, ax_d;
  logic [IW-1:0]       cur_idx_q, cur_idx_d;
  logic [MAX_POINTS-1:0] visited_q, visited_d;
  logic                start_leftmost_q;

  logic                s_acc;
  logic                room;
  logic                out_free;
  logic                last_grab;
  logic                mem_we;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                iss;
  axis_e               iss_ax;
  logic                grab;
  logic                found_clr;
  logic                cfg_we;

  logic [ROW_W-1:0]    coord_mem_q [MAX_POINTS];
  logic [ROW_W-1:0]    rd_q;
  logic [ROW_W-1:0]    cur_q;

  tag_t                p1_q, p2_q, p3_q, p4_q;
  logic [IW-1:0]       p1_idx_q, p2_idx_q, p3_idx_q, p4_idx_q;
  logic [CW-1:0]       rd_ax, cur_ax;
  logic signed [CW:0]  diff_d, diff_q;
  logic signed [DW-1:0] prod;
  logic [DW-1:0]       sq_q;
  logic [DW-1:0]       acc_q;
  logic [DW-1:0]       dist_sum;
  logic                pipe_busy;

  logic                found_q;
  logic [DW-1:0]       best_q;
  logic [IW-1:0]       next_idx_q;
  logic [CW-1:0]       min_x_q;

  logic                m_valid_q;
  logic [OUT_W-1:0]    m_data_q;
  logic                m_last_q;

  // handshake terms
  assign s_axis_tready = (state_q == ST_LOAD);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign room          = (count_q < CNT_W'(MAX_POINTS));
  assign mem_we        = s_acc && room;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign last_grab     = ((emit_q + CNT_W'(1)) == n_q);
  assign pipe_busy     = p1_q.valid || p2_q.valid || p3_q.valid || p4_q.valid;

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    n_d       = n_q;
    emit_d    = emit_q;
    ic_d      = ic_q;
    ax_d      = ax_q;
    cur_idx_d = cur_idx_q;
    visited_d = visited_q;
    iss       = 1'b0;
    iss_ax    = ax_q;
    rd_en     = 1'b0;
    rd_addr   = ic_q[IW-1:0];
    grab      = 1'b0;
    found_clr = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (s_acc) begin
          if (room) begin
            count_d = count_q + CNT_W'(1);
          end
          if (s_axis_tlast) begin
            n_d       = room ? count_q + CNT_W'(1) : count_q;
            emit_d    = '0;
            ic_d      = '0;
            ax_d      = AX_X;
            cur_idx_d = '0;
            found_clr = 1'b1;
            state_d   = start_leftmost_q ? ST_LEFT : ST_FETCH;
          end
        end
      end
      ST_LEFT: begin
        // one x coordinate read per cycle, compared in the cycle after
        if (ic_q < n_q) begin
          iss    = 1'b1;
          iss_ax = AX_X;
          rd_en  = 1'b1;
          ic_d   = ic_q + CNT_W'(1);
        end else if (!p1_q.valid) begin
          cur_idx_d = next_idx_q;
          state_d   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = cur_idx_q;
        state_d = ST_GRAB;
      end
      ST_GRAB: begin
        if (out_free) begin
          grab                 = 1'b1;
          visited_d[cur_idx_q] = 1'b1;
          emit_d               = emit_q + CNT_W'(1);
          if (last_grab) begin
            count_d   = '0;
            visited_d = '0;
            state_d   = ST_LOAD;
          end else begin
            ic_d      = '0;
            ax_d      = AX_X;
            found_clr = 1'b1;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // visited points are skipped without a read, others are issued one axis at a time
        if (ic_q < n_q) begin
          if ((ax_q == AX_X) && visited_q[ic_q[IW-1:0]]) begin
            ic_d = ic_q + CNT_W'(1);
          end else begin
            iss   = 1'b1;
            rd_en = (ax_q == AX_X);
            case (ax_q)
              AX_X: ax_d = AX_Y;
              AX_Y: ax_d = AX_Z;
              default: begin
                ax_d = AX_X;
                ic_d = ic_q + CNT_W'(1);
              end
            endcase
          end
        end else if (!pipe_busy) begin
          cur_idx_d = next_idx_q;
          state_d   = ST_FETCH;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      n_q       <= '0;
      emit_q    <= '0;
      ic_q      <= '0;
      ax_q      <= AX_X;
      cur_idx_q <= '0;
      visited_q <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      n_q       <= n_d;
      emit_q    <= emit_d;
      ic_q      <= ic_d;
      ax_q      <= ax_d;
      cur_idx_q <= cur_idx_d;
      visited_q <= visited_d;
    end
  end

  // coordinate store, one row per point, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coord_mem_q[count_q[IW-1:0]] <= s_axis_tdata[ROW_W-1:0];
    end
    if (rd_en) begin
      rd_q <= coord_mem_q[rd_addr];
    end
  end

  // pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '{valid: 1'b0, axis: AX_X};
      p2_q <= '{valid: 1'b0, axis: AX_X};
      p3_q <= '{valid: 1'b0, axis: AX_X};
      p4_q <= '{valid: 1'b0, axis: AX_X};
    end else begin
      p1_q <= '{valid: iss, axis: iss_ax};
      p2_q <= '{valid: p1_q.valid && (state_q == ST_SCAN), axis: p1_q.axis};
      p3_q <= p2_q;
      p4_q <= p3_q;
    end
  end

  // axis select for the shared unit
  always_comb begin
    case (p1_q.axis)
      AX_Y: begin
        rd_ax  = rd_q[2*CW-1:CW];
        cur_ax = cur_q[2*CW-1:CW];
      end
      AX_Z: begin
        rd_ax  = rd_q[3*CW-1:2*CW];
        cur_ax = cur_q[3*CW-1:2*CW];
      end
      default: begin
        rd_ax  = rd_q[CW-1:0];
        cur_ax = cur_q[CW-1:0];
      end
    endcase
  end

  assign diff_d = {rd_ax[CW-1], rd_ax} - {cur_ax[CW-1], cur_ax};
  assign prod   = diff_q * diff_q;

  // subtract, square, accumulate: one axis per cycle
  always_ff @(posedge clk_i) begin
    p1_idx_q <= ic_q[IW-1:0];
    p2_idx_q <= p1_idx_q;
    p3_idx_q <= p2_idx_q;
    p4_idx_q <= p3_idx_q;
    diff_q   <= diff_d;
    sq_q     <= prod;
    acc_q    <= ((p3_q.axis == AX_X) ? '0 : acc_q) + sq_q;
    if (grab) begin
      cur_q <= rd_q;
    end
  end

  // distance clipped to 64 bits when it is wider than that
  if (DW > SAT_W) begin : g_sat
    assign dist_sum = (|acc_q[DW-1:SAT_W]) ? DW'({SAT_W{1'b1}}) : acc_q;
  end else begin : g_nosat
    assign dist_sum = acc_q;
  end

  // running minimum, first hit wins on a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      best_q     <= '0;
      next_idx_q <= '0;
      min_x_q    <= '0;
    end else if (found_clr) begin
      found_q    <= 1'b0;
      next_idx_q <= '0;
    end else if ((state_q == ST_LEFT) && p1_q.valid) begin
      if (!found_q || ($signed(rd_q[CW-1:0]) < $signed(min_x_q))) begin
        found_q    <= 1'b1;
        min_x_q    <= rd_q[CW-1:0];
        next_idx_q <= p1_idx_q;
      end
    end else if ((state_q == ST_SCAN) && p4_q.valid && (p4_q.axis == AX_Z)) begin
      if (!found_q || (dist_sum < best_q)) begin
        found_q    <= 1'b1;
        best_q     <= dist_sum;
        next_idx_q <= p4_idx_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (grab) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grab) begin
      m_data_q <= OUT_W'({rd_q, INDEX_W'(cur_idx_q)});
      m_last_q <= last_grab;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // config register
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_START_LEFTMOST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_leftmost_q <= 1'b0;
    end else if (cfg_we) begin
      start_leftmost_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_LEFTMOST) ? APB_DATA_W'(start_leftmost_q) : '0;

endmodule

// ----- sv/nnpo_chk.sv -----
module nnpo_chk
  import nnpo_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24,
  localparam int unsigned OUT_W = ((INDEX_W + 3 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  // point_index, out_x, out_y, out_z
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_W-1:0]      m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a closing point makes the block busy
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after closing point");

  // an ordinary point keeps loading open
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
    else $error("input closed without a closing point");

  // a pending non-final result means ordering is in progress
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open while a set is still being sent");

  // written start option reads back
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == REG_START_LEFTMOST) |=>
      (paddr[2] != REG_START_LEFTMOST) || (prdata[0] == $past(pwdata[0])))
    else $error("start option readback mismatch");

endmodule

bind nearest_neighbor_point_order_top nnpo_chk #(.COORD_WIDTH(COORD_WIDTH)) u_nnpo_chk (.*);

// ----- bench/tb_nearest_neighbor_point_order_top.sv -----
module tb_nearest_neighbor_point_order_top;
  import nnpo_pkg::*;

  // one point request on the input stream
  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        last;
  } point_req_t;

  // one point of the emitted tour
  typedef struct {
    logic [5:0]  idx;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        last;
  } tour_pt_t;

  localparam logic [23:0] C_MAX  = 24'h7FFFFF;
  localparam logic [23:0] C_MIN  = 24'h800000;
  localparam logic [23:0] C_ZERO = 24'h000000;
  localparam logic [23:0] C_NEG1 = 24'hFFFFFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [71:0]           s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [79:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // pending requests, expected tour, bookkeeping
  point_req_t pend_q[$];
  tour_pt_t   tour_q[$];
  int         errors = 0;
  int         queued = 0;
  int         accepted = 0;
  bit         in_fire = 1'b0;
  bit         out_fire = 1'b0;
  bit         calm = 1'b0;
  bit         hold_armed = 1'b0;
  int         snd_gap = 0;
  int         rdy_gap = 0;
  int         hold_left = 0;

  // shadow of the point store and the start register
  logic signed [23:0] pt_x [64];
  logic signed [23:0] pt_y [64];
  logic signed [23:0] pt_z [64];
  int                 pt_count = 0;
  bit                 from_left = 1'b0;

  nearest_neighbor_point_order_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] sq_dist(int a, int b);
    longint dx, dy, dz;
    dx = longint'(pt_x[a]) - longint'(pt_x[b]);
    dy = longint'(pt_y[a]) - longint'(pt_y[b]);
    dz = longint'(pt_z[a]) - longint'(pt_z[b]);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // store a point; on the closing request build the greedy tour
  task automatic load_point(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic last);
    bit          seen [64];
    int          n, cur, nxt, i, k;
    bit          found;
    logic [63:0] d, best;
    tour_pt_t    r;
    if (pt_count < 64) begin
      pt_x[pt_count] = x;
      pt_y[pt_count] = y;
      pt_z[pt_count] = z;
      pt_count++;
    end
    if (!last) return;
    n = pt_count;
    cur = 0;
    best = '0;
    nxt = 0;
    if (from_left) begin
      for (i = 1; i < n; i++)
        if (pt_x[i] < pt_x[cur]) cur = i;
    end
    for (k = 0; k < n; k++) begin
      seen[cur] = 1'b1;
      r.idx  = cur[5:0];
      r.x    = pt_x[cur];
      r.y    = pt_y[cur];
      r.z    = pt_z[cur];
      r.last = (k == n - 1);
      tour_q.push_back(r);
      found = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!seen[i]) begin
          d = sq_dist(cur, i);
          if (!found || d < best) begin
            found = 1'b1;
            best = d;
            nxt = i;
          end
        end
      end
      if (!found) break;
      cur = nxt;
    end
    pt_count = 0;
  endtask

  task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // sender: one request held until taken, then an optional gap
  always @(negedge clk_i) begin
    point_req_t item;
    if (!s_axis_tvalid || in_fire) begin
      if (snd_gap > 0) begin
        snd_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        item = pend_q.pop_front();
        s_axis_tdata  <= {item.z, item.y, item.x};
        s_axis_tlast  <= item.last;
        s_axis_tvalid <= 1'b1;
        snd_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold when armed
  always @(negedge clk_i) begin
    if (out_fire) rdy_gap = pick_gap();
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_armed && m_axis_tvalid) begin
      hold_armed = 1'b0;
      hold_left = 600;
      m_axis_tready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: predict on input requests, compare output requests
  always @(posedge clk_i) begin
    tour_pt_t want;
    in_fire  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      accepted++;
      load_point(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tdata[71:48], s_axis_tlast);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tour_q.size() == 0) begin
        $display("%0t: unexpected point, expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = tour_q.pop_front();
        check_field("point_index", 24'(want.idx), 24'(m_axis_tdata[5:0]));
        check_field("out_x", want.x, m_axis_tdata[29:6]);
        check_field("out_y", want.y, m_axis_tdata[53:30]);
        check_field("out_z", want.z, m_axis_tdata[77:54]);
        check_field("last_out", 24'(want.last), 24'(m_axis_tlast));
      end
    end
  end

  task automatic push_point(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic last);
    point_req_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    pend_q.push_back(p);
    queued++;
  endtask

  // coordinate styles: full range, a small box for ties, extremes
  function automatic logic [23:0] rand_coord(int style);
    int v;
    case (style)
      0: return 24'($urandom);
      1: begin
        v = $urandom_range(0, 128);
        return 24'(v - 64);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return C_MAX;
          1: return C_MIN;
          2: return C_ZERO;
          default: return C_NEG1;
        endcase
      end
    endcase
  endfunction

  // one set of n points; style below zero mixes styles per point
  task automatic queue_set(int n, int style);
    int i, s;
    for (i = 0; i < n; i++) begin
      s = (style < 0) ? $urandom_range(0, 2) : style;
      push_point(rand_coord(s), rand_coord(s), rand_coord(s), i == n - 1);
    end
  endtask

  // block is idle once every request is in and every point is out
  task automatic wait_idle();
    do @(negedge clk_i); while (!(accepted == queued && tour_q.size() == 0));
    repeat (30) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[2] == REG_START_LEFTMOST) from_left = data[0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // run limit
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int p, budget, n;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    #1 rst_ni = 1'b1;

    // write to an unused register index must not change the start rule
    apb_write(3'd4, 32'h1);
    @(posedge clk_i);
    // single point
    push_point(C_MAX, C_MIN, C_ZERO, 1'b1);
    // extremes of every coordinate
    push_point(C_MAX, C_MAX, C_MAX, 1'b0);
    push_point(C_MIN, C_MIN, C_MIN, 1'b0);
    push_point(C_ZERO, C_ZERO, C_ZERO, 1'b0);
    push_point(C_NEG1, 24'd1, C_NEG1, 1'b1);
    // equal distances and a duplicate point
    push_point(C_ZERO, C_ZERO, C_ZERO, 1'b0);
    push_point(24'd16, C_ZERO, C_ZERO, 1'b0);
    push_point(-24'sd16, C_ZERO, C_ZERO, 1'b0);
    push_point(C_ZERO, 24'd16, C_ZERO, 1'b0);
    push_point(C_ZERO, C_ZERO, C_ZERO, 1'b1);
    wait_idle();

    // leftmost start, tie on the smallest x
    apb_write(3'd0, 32'h1);
    @(posedge clk_i);
    push_point(24'd5, 24'd0, 24'd0, 1'b0);
    push_point(-24'sd3, 24'd1, 24'd1, 1'b0);
    push_point(24'd7, 24'd2, 24'd2, 1'b0);
    push_point(-24'sd3, 24'd3, 24'd3, 1'b1);
    // point 0 is leftmost and tied with a later one
    push_point(C_MIN, 24'd0, 24'd0, 1'b0);
    push_point(C_ZERO, 24'd0, 24'd0, 1'b0);
    push_point(C_MIN, 24'd5, 24'd5, 1'b1);
    wait_idle();

    // random phases, start rule alternating between both settings
    for (p = 0; p < 6; p++) begin
      apb_write(3'd0, ($urandom & 32'hFFFF_FFFE) | 32'(p % 2));
      @(posedge clk_i);
      calm = (p == 1);
      if (p == 2) hold_armed = 1'b1;
      if (p == 3) queue_set(64, -1);
      if (p == 4) queue_set(66, -1);
      budget = 0;
      while (budget < 8) begin
        n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 20);
        queue_set(n, -1);
        budget += n;
      end
      wait_idle();
    end

    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
